// ----- rtl/skti_pkg.sv -----
// Shared types and constants for the security key table installer.
package skti_pkg;

  localparam int unsigned MaxUsers       = 64;
  localparam int unsigned TypeBaseRow    = 24;
  localparam int unsigned DefaultTypeRow = 26;
  localparam int unsigned KeyBaseRow     = 27;

  localparam int unsigned RowWidth     = 128;
  localparam int unsigned AddrRows     = 24;
  localparam int unsigned AddrRowWidth = $clog2(AddrRows);
  localparam int unsigned TypeRows     = 3;
  localparam int unsigned MacBytes     = 6;

  typedef struct packed {
    logic        mode;
    logic [7:0]  user;
    logic [1:0]  key_id;
    logic [3:0]  cipher_type;
    logic [47:0] mac_address;
    logic [63:0] key_low;
    logic [63:0] key_high;
  } skti_in_t;

  typedef struct packed {
    logic        write_valid;
    logic [7:0]  write_row;
    logic [63:0] row_low;
    logic [63:0] row_high;
    logic [63:0] enable_map;
    logic        status;
    logic        last;
  } skti_out_t;

  typedef struct packed {
    logic capture;
    logic emit_single;
    logic emit_type;
    logic emit_addr;
    logic emit_key;
  } skti_cmd_t;

  typedef struct packed {
    logic single;
    logic station;
    logic last_addr;
    logic out_free;
  } skti_stat_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StExec = 4'b0010,
    StAddr = 4'b0100,
    StKey  = 4'b1000
  } skti_state_e;

endpackage

// ----- rtl/security_key_table_installer_unit.sv -----
// Top level of the security key table installer.
// Commands arrive on the input channel (in_valid_i, in_ready_o, in_data_i) and
// each table row write leaves on the output channel (out_valid_o, out_ready_i,
// out_data_o) as one transfer, in order, with last marking the final one.
// A station key install gives eight transfers: the type row, six address rows
// and the key row. A default-key install gives two, and a disable command or a
// rejected install gives one transfer without a row write.
// The sequencer handles one command at a time and emits at most one result per
// cycle into a single output register, and only while that register is empty or
// is being taken by the receiver.
// The address rows live in a 24 x 128 bit RAM; the next row is read while the
// current one is written, which sets the one-row-per-cycle pace absent receiver stalls.
// While the receiver stalls the sequencer holds its place and the final result
// waits in the output register while the next command may be accepted.
// Reset empties the output register, clears the enable map and type rows and
// marks all address rows as zero; no clearing pass is needed.
module security_key_table_installer_unit import skti_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  skti_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output skti_out_t out_data_o
);

  skti_cmd_t  cmd;
  skti_stat_t stat;

  skti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  skti_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

endmodule

// ----- rtl/skti_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module skti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/skti_ctrl.sv -----
// Command sequencer that steps through the row writes of one key command.
module skti_ctrl import skti_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  skti_stat_t stat_i,
  output skti_cmd_t  cmd_o
);

  skti_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        if (stat_i.out_free) begin
          if (stat_i.single) begin
            cmd_o.emit_single = 1'b1;
            state_d           = StIdle;
          end else begin
            cmd_o.emit_type = 1'b1;
            state_d         = stat_i.station ? StAddr : StKey;
          end
        end
      end
      StAddr: begin
        if (stat_i.out_free) begin
          cmd_o.emit_addr = 1'b1;
          if (stat_i.last_addr) begin
            state_d = StKey;
          end
        end
      end
      StKey: begin
        if (stat_i.out_free) begin
          cmd_o.emit_key = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

// ----- rtl/skti_dp.sv -----
// Datapath with the command register, table shadow rows, enable map and result register.
module skti_dp import skti_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  skti_in_t   in_i,
  input  skti_cmd_t  cmd_i,
  output skti_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output skti_out_t  out_o
);

  skti_in_t                  cmd_q;
  logic [63:0]               en_q, en_d;
  logic [RowWidth-1:0]       trow_q [TypeRows];
  logic [AddrRows-1:0]       avld_q;
  logic [2:0]                idx_q, idx_d;
  logic                      rd_vld_q;
  logic                      out_valid_q, out_valid_d;
  skti_out_t                 out_q, out_d;

  logic [7:0]                user;
  logic                      station, reject, single, last_addr;
  logic [63:0]               en_bit, en_clr, en_set;
  logic [1:0]                tsel;
  logic [7:0]                dflt_off;
  logic [4:0]                nib_idx;
  logic [RowWidth-1:0]       type_old, type_new;
  logic [7:0]                type_row;
  logic [AddrRowWidth-1:0]   abase, arow, raddr;
  logic [7:0]                mac_byte;
  logic [RowWidth-1:0]       ram_rdata, a_old, a_new;
  logic [7:0]                key_row;
  logic                      re;

  assign user      = cmd_q.user;
  assign station   = user < 8'(MaxUsers);
  assign reject    = (user > 8'(MaxUsers + 3)) || cmd_q.key_id[1];
  assign single    = cmd_q.mode || reject;
  assign last_addr = (idx_q == 3'(MacBytes - 1));

  assign en_bit = (user[7:6] == 2'b00) ? (64'd1 << user[5:0]) : '0;
  assign en_clr = en_q & ~en_bit;
  assign en_set = en_q | en_bit;

  // Station users share two type rows; the default-key slots use a third.
  assign tsel     = station ? {1'b0, user[5]} : 2'd2;
  assign dflt_off = user - 8'(MaxUsers);
  assign nib_idx  = station ? user[4:0] : {2'b00, dflt_off[2:0]};
  assign type_row = station ? 8'(TypeBaseRow) + {7'b0, user[5]} : 8'(DefaultTypeRow);

  always_comb begin
    case (tsel)
      2'd0:    type_old = trow_q[0];
      2'd1:    type_old = trow_q[1];
      2'd2:    type_old = trow_q[2];
      default: type_old = '0;
    endcase
  end

  assign type_new = (type_old & ~(RowWidth'(4'hf) << {nib_idx, 2'b00}))
                  | (RowWidth'(cmd_q.cipher_type) << {nib_idx, 2'b00});

  // Six address rows per group of sixteen stations; byte position is user[3:0].
  assign abase    = AddrRowWidth'({user[5:4], 2'b00}) + AddrRowWidth'({user[5:4], 1'b0});
  assign arow     = abase + AddrRowWidth'(idx_q);
  assign mac_byte = 8'(cmd_q.mac_address >> {idx_q, 3'b000});
  assign a_old    = rd_vld_q ? ram_rdata : '0;
  assign a_new    = (a_old & ~(RowWidth'(8'hff) << {user[3:0], 3'b000}))
                  | (RowWidth'(mac_byte) << {user[3:0], 3'b000});

  assign key_row = 8'(KeyBaseRow) + {user[6:0], 1'b0} + {7'b0, cmd_q.key_id[0]};

  // The next address row is read while the current one is written back.
  assign re    = (cmd_i.emit_type && station) || (cmd_i.emit_addr && !last_addr);
  assign raddr = cmd_i.emit_type ? abase : arow + AddrRowWidth'(1);

  skti_ram #(
    .Width (RowWidth),
    .Depth (AddrRows)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.emit_addr),
    .waddr_i (arow),
    .wdata_i (a_new),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    en_d = en_q;
    if ((cmd_i.emit_single && cmd_q.mode) || cmd_i.emit_type) begin
      en_d = en_clr;
    end else if (cmd_i.emit_key) begin
      en_d = en_set;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.emit_type) begin
      idx_d = '0;
    end else if (cmd_i.emit_addr) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit_single) begin
      out_valid_d = 1'b1;
      out_d       = '{write_valid: 1'b0, write_row: '0, row_low: '0, row_high: '0,
                      enable_map: cmd_q.mode ? en_clr : en_q,
                      status: !cmd_q.mode, last: 1'b1};
    end else if (cmd_i.emit_type) begin
      out_valid_d = 1'b1;
      out_d       = '{write_valid: 1'b1, write_row: type_row,
                      row_low: type_new[63:0], row_high: type_new[127:64],
                      enable_map: en_clr, status: 1'b0, last: 1'b0};
    end else if (cmd_i.emit_addr) begin
      out_valid_d = 1'b1;
      out_d       = '{write_valid: 1'b1, write_row: 8'(arow),
                      row_low: a_new[63:0], row_high: a_new[127:64],
                      enable_map: en_q, status: 1'b0, last: 1'b0};
    end else if (cmd_i.emit_key) begin
      out_valid_d = 1'b1;
      out_d       = '{write_valid: 1'b1, write_row: key_row,
                      row_low: cmd_q.key_low, row_high: cmd_q.key_high,
                      enable_map: en_set, status: 1'b0, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= in_i;
    end
    out_q <= out_d;
    idx_q <= idx_d;
    if (re) begin
      rd_vld_q <= avld_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= '0;
      avld_q      <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < TypeRows; r++) begin
        trow_q[r] <= '0;
      end
    end else begin
      en_q        <= en_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.emit_addr) begin
        avld_q[arow] <= 1'b1;
      end
      if (cmd_i.emit_type) begin
        for (int r = 0; r < TypeRows; r++) begin
          if (tsel == 2'(r)) begin
            trow_q[r] <= type_new;
          end
        end
      end
    end
  end

  assign stat_o = '{single: single, station: station, last_addr: last_addr,
                    out_free: !out_valid_q || out_ready_i};

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- tb/sv/security_key_table_installer_unit_tb.sv -----
// Self-checking testbench for the security key table installer with a row-level predictor.
module security_key_table_installer_unit_tb;
  import skti_pkg::*;

  localparam logic        ModeInstall   = 1'b0;
  localparam logic        ModeDisable   = 1'b1;
  localparam int unsigned KeyIdMax      = 1;
  localparam int unsigned RandomCmds    = 310;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 32;

  typedef struct {
    skti_in_t cmd;
    bit       drain;
  } pending_cmd_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  skti_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  skti_out_t out_data_o;

  logic [31:0] addr_words [0:4*AddrRows-1];
  logic [31:0] type_words [0:4*TypeRows-1];
  logic [63:0] user_enables;

  pending_cmd_t cmd_q[$];
  pending_cmd_t next_cmd;
  skti_out_t    row_writes_q[$];

  int unsigned predicted_cnt = 0;
  int unsigned checked_cnt   = 0;
  int unsigned err_cnt       = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_stall    = 0;
  int unsigned new_rows;
  bit          quiet         = 1'b0;

  security_key_table_installer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_cmd(logic mode, logic [7:0] user, logic [1:0] key_id,
                                  logic [3:0] ctype, logic [47:0] mac, logic [63:0] klo,
                                  logic [63:0] khi, bit drain);
    pending_cmd_t p;
    p.cmd.mode        = mode;
    p.cmd.user        = user;
    p.cmd.key_id      = key_id;
    p.cmd.cipher_type = ctype;
    p.cmd.mac_address = mac;
    p.cmd.key_low     = klo;
    p.cmd.key_high    = khi;
    p.drain           = drain;
    cmd_q.push_back(p);
  endfunction

  function automatic void expect_row(logic valid, int unsigned row, logic [63:0] lo,
                                     logic [63:0] hi, logic status, logic last);
    skti_out_t r;
    r.write_valid = valid;
    r.write_row   = row[7:0];
    r.row_low     = lo;
    r.row_high    = hi;
    r.enable_map  = user_enables;
    r.status      = status;
    r.last        = last;
    row_writes_q.push_back(r);
  endfunction

  task automatic predict_rows(input skti_in_t c, output int unsigned n);
    int unsigned u;
    int unsigned trow;
    int unsigned tidx;
    int unsigned word;
    int unsigned nib;
    int unsigned byte_sel;
    int unsigned base;
    int unsigned row;
    int unsigned w;
    u = c.user;
    n = 1;
    if (c.mode == ModeDisable) begin
      if (u < $bits(user_enables)) user_enables[u] = 1'b0;
      expect_row(1'b0, 0, '0, '0, 1'b0, 1'b1);
      return;
    end
    if (u > MaxUsers + 3 || c.key_id > KeyIdMax) begin
      expect_row(1'b0, 0, '0, '0, 1'b1, 1'b1);
      return;
    end
    if (u < $bits(user_enables)) user_enables[u] = 1'b0;
    if (u >= MaxUsers) begin
      trow = DefaultTypeRow;
      tidx = 2;
      word = 0;
      nib  = (u - MaxUsers) & 7;
    end else begin
      trow = TypeBaseRow + (u >> 5);
      tidx = (u >> 5) & 1;
      word = (u >> 3) & 3;
      nib  = u & 7;
    end
    w = tidx * 4;
    type_words[w + word][nib*4 +: 4] = c.cipher_type;
    expect_row(1'b1, trow, {type_words[w+1], type_words[w]},
               {type_words[w+3], type_words[w+2]}, 1'b0, 1'b0);
    if (u < MaxUsers) begin
      byte_sel = u & 3;
      base     = (u >> 4) * MacBytes;
      word     = (u >> 2) & 3;
      for (int i = 0; i < MacBytes; i++) begin
        row = base + i;
        w   = (row % AddrRows) * 4;
        addr_words[w + word][byte_sel*8 +: 8] = c.mac_address[i*8 +: 8];
        expect_row(1'b1, row, {addr_words[w+1], addr_words[w]},
                   {addr_words[w+3], addr_words[w+2]}, 1'b0, 1'b0);
      end
      n = 8;
    end else begin
      n = 2;
    end
    if (u < $bits(user_enables)) user_enables[u] = 1'b1;
    expect_row(1'b1, (KeyBaseRow + u * 2 + c.key_id) & 8'hff, c.key_low, c.key_high,
               1'b0, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_rows(in_data_i, new_rows);
        predicted_cnt <= predicted_cnt + new_rows;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (cmd_q.size() > 0 &&
                     (!cmd_q[0].drain ||
                      (!in_valid_i && predicted_cnt == checked_cnt))) begin
          next_cmd    = cmd_q.pop_front();
          in_data_i  <= next_cmd.cmd;
          in_valid_i <= 1'b1;
          send_gap   <= pick_gap();
          if ($urandom_range(0, 49) == 0) quiet = ~quiet;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        checked_cnt <= checked_cnt + 1;
        if (row_writes_q.size() == 0) begin
          $error("unexpected transfer: write_row %0h last %0b",
                 out_data_o.write_row, out_data_o.last);
          err_cnt++;
        end else begin
          skti_out_t e;
          e = row_writes_q.pop_front();
          if (out_data_o.write_valid !== e.write_valid) begin
            $error("write_valid: expected %0h, actual %0h", e.write_valid,
                   out_data_o.write_valid);
            err_cnt++;
          end
          if (out_data_o.write_row !== e.write_row) begin
            $error("write_row: expected %0h, actual %0h", e.write_row, out_data_o.write_row);
            err_cnt++;
          end
          if (out_data_o.row_low !== e.row_low) begin
            $error("row_low: expected %0h, actual %0h", e.row_low, out_data_o.row_low);
            err_cnt++;
          end
          if (out_data_o.row_high !== e.row_high) begin
            $error("row_high: expected %0h, actual %0h", e.row_high, out_data_o.row_high);
            err_cnt++;
          end
          if (out_data_o.enable_map !== e.enable_map) begin
            $error("enable_map: expected %0h, actual %0h", e.enable_map,
                   out_data_o.enable_map);
            err_cnt++;
          end
          if (out_data_o.status !== e.status) begin
            $error("status: expected %0h, actual %0h", e.status, out_data_o.status);
            err_cnt++;
          end
          if (out_data_o.last !== e.last) begin
            $error("last: expected %0h, actual %0h", e.last, out_data_o.last);
            err_cnt++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("security_key_table_installer_unit_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned r;
    logic [7:0]  u;
    foreach (addr_words[i]) addr_words[i] = '0;
    foreach (type_words[i]) type_words[i] = '0;
    user_enables = '0;

    // Corner values first: field extremes, every user class and every rejection.
    add_cmd(ModeInstall, 8'd0, 2'd0, 4'hf, '1, '1, '1, 1'b0);
    add_cmd(ModeInstall, 8'd0, 2'd1, 4'h0, '0, '0, '0, 1'b0);
    add_cmd(ModeInstall, 8'd63, 2'd1, 4'hf, 48'($urandom), rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd31, 2'd0, 4'ha, '1, rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd32, 2'd1, 4'h5, 48'($urandom), rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd1, 2'd0, 4'h3, '1, rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd2, 2'd1, 4'hc, 48'({$urandom, $urandom}), rand64(), rand64(),
            1'b0);
    add_cmd(ModeInstall, 8'd47, 2'd0, 4'h9, '0, rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd64, 2'd0, 4'hf, '1, '1, '1, 1'b0);
    add_cmd(ModeInstall, 8'd65, 2'd1, 4'h6, '1, rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd66, 2'd0, 4'h1, '0, rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd67, 2'd1, 4'he, '0, '1, '0, 1'b0);
    add_cmd(ModeInstall, 8'd68, 2'd0, 4'h7, '1, rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd255, 2'd1, 4'hf, '1, '1, '1, 1'b0);
    add_cmd(ModeInstall, 8'd0, 2'd2, 4'h4, '1, rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd5, 2'd3, 4'hb, '0, rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd64, 2'd3, 4'h2, '1, rand64(), rand64(), 1'b0);
    add_cmd(ModeDisable, 8'd0, 2'd3, 4'hf, '1, '1, '1, 1'b0);
    add_cmd(ModeDisable, 8'd63, 2'd0, 4'h0, '0, '0, '0, 1'b0);
    add_cmd(ModeDisable, 8'd64, 2'd1, 4'h8, '0, '0, '0, 1'b0);
    add_cmd(ModeDisable, 8'd255, 2'd2, 4'h3, '1, rand64(), rand64(), 1'b0);
    add_cmd(ModeDisable, 8'd31, 2'd0, 4'h0, 48'($urandom), rand64(), rand64(), 1'b0);
    add_cmd(ModeInstall, 8'd63, 2'd0, 4'h0, '1, rand64(), rand64(), 1'b0);

    for (int i = 0; i < RandomCmds; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        u = 8'($urandom_range(0, MaxUsers - 1));
        add_cmd(ModeInstall, u, 2'($urandom_range(0, KeyIdMax)), 4'($urandom),
                48'({$urandom, $urandom}), rand64(), rand64(),
                i == 0 || $urandom_range(0, 32) == 0);
      end else if (r < 80) begin
        u = 8'($urandom_range(MaxUsers, MaxUsers + 3));
        add_cmd(ModeInstall, u, 2'($urandom_range(0, KeyIdMax)), 4'($urandom),
                48'({$urandom, $urandom}), rand64(), rand64(), 1'b0);
      end else if (r < 90) begin
        u = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, MaxUsers + 3));
        add_cmd(ModeDisable, u, 2'($urandom), 4'($urandom), 48'({$urandom, $urandom}),
                rand64(), rand64(), 1'b0);
      end else begin
        add_cmd(ModeInstall, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                4'($urandom), 48'({$urandom, $urandom}), rand64(), rand64(), 1'b0);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (cmd_q.size() != 0 || in_valid_i);
    while (predicted_cnt != checked_cnt) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (row_writes_q.size() != 0) begin
      $error("%0d expected transfers never arrived", row_writes_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("security_key_table_installer_unit_tb: done, clean");
    end else begin
      $display("security_key_table_installer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- security_key_table_installer_unit.f -----
rtl/skti_pkg.sv
rtl/skti_ram.sv
rtl/skti_ctrl.sv
rtl/skti_dp.sv
rtl/security_key_table_installer_unit.sv
tb/sv/security_key_table_installer_unit_tb.sv
